### hw/rtl/pid_antiwindup_bumpless_unit_assert.svh
`ifndef PID_ANTIWINDUP_BUMPLESS_UNIT_ASSERT_SVH
`define PID_ANTIWINDUP_BUMPLESS_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset
`define PIDAB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pidab check failed");

// Next-cycle implication, sampled on clk, off during reset
`define PIDAB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pidab check failed");

`endif

### hw/rtl/pidab_pkg.sv
package pidab_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int PC_W       = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_OMIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OMAX   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_KP     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_KI     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_KD     = 3'd7;

    localparam logic [31:0] RST_OMIN   = 32'hFC18_0000;
    localparam logic [31:0] RST_OMAX   = 32'd65536000;
    localparam logic [15:0] RST_PERIOD = 16'd66;
    localparam logic [15:0] RST_RATE   = 16'd1000;
    localparam logic [15:0] RST_ALPHA  = 16'd58982;
    localparam logic [23:0] RST_KP     = 24'd65536;
    localparam logic [23:0] RST_KI     = 24'd0;
    localparam logic [23:0] RST_KD     = 24'd0;

    localparam logic [2:0] ST_NORMAL      = 3'd0;
    localparam logic [2:0] ST_FAULT_FIRST = 3'd1;
    localparam logic [2:0] ST_FAULT_AGAIN = 3'd2;
    localparam logic [2:0] ST_REQ_OK      = 3'd3;
    localparam logic [2:0] ST_REQ_BUSY    = 3'd4;

    localparam logic signed [74:0] S48_MAX_W = 75'sd140737488355327;
    localparam logic signed [74:0] S48_MIN_W = -75'sd140737488355328;

    typedef struct packed {
        logic        req_type;
        logic [31:0] target;
        logic [31:0] actual;
        logic        inputs_valid;
        logic [23:0] new_kp;
        logic [23:0] new_ki;
        logic [23:0] new_kd;
    } in_item_t;

    typedef struct packed {
        logic [31:0] drive;
        logic [2:0]  status;
        logic        gains_applied;
    } out_item_t;

    typedef enum logic [1:0] {UK_ALU, UK_MUL, UK_DIV} kind_t;
    typedef enum logic [2:0] {C_ALWAYS, C_PEND, C_APGI, C_PRIMED, C_NOCOMMIT} cond_t;
    typedef enum logic [2:0] {A_ERR, A_DMEAS, A_RAW, A_FD, A_CAND, A_INTEG} asel_t;
    typedef enum logic [2:0] {B_GP, B_GI, B_GD, B_RATE, B_PERIOD, B_ALPHA, B_NALPHA} bsel_t;
    typedef enum logic [1:0] {D_NUM, D_MIN, D_MAX} dsel_t;
    typedef enum logic [3:0] {
        W_NONE, W_NUM, W_RAW, W_FD1, W_FD2, W_CAND, W_SUM0, W_SUMA,
        W_UNSAT, W_OUT, W_Q, W_LO, W_HI
    } wb_t;
    typedef enum logic [1:0] {AL_NONE, AL_APPLY, AL_CLAMPI, AL_FINISH} alu_t;
    typedef enum logic [1:0] {TK_NONE, TK_REQ, TK_FAULT, TK_VALID} tick_t;

    typedef struct packed {
        kind_t kind;
        cond_t cond;
        asel_t asel;
        bsel_t bsel;
        dsel_t dsel;
        wb_t   wb;
        alu_t  alu;
    } uop_t;

    typedef struct packed {
        logic  take_in;
        tick_t tick;
        logic  mul_start;
        asel_t asel;
        bsel_t bsel;
        logic  div_start;
        dsel_t dsel;
        wb_t   wb;
        alu_t  alu;
        logic  load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic req_type;
        logic inputs_valid;
        logic pend_valid;
        logic primed;
        logic applied;
        logic gi_nz;
        logic commit;
        logic mul_done;
        logic div_done;
    } dp_stat_t;

    localparam logic [PC_W-1:0] PC_LAST = 4'd14;

    // Program of a valid tick
    function automatic uop_t get_uop(input logic [PC_W-1:0] pc);
        case (pc)
            4'd0:  return '{UK_ALU, C_PEND,     A_ERR,   B_GP,     D_NUM, W_NONE,  AL_APPLY};
            4'd1:  return '{UK_MUL, C_APGI,     A_ERR,   B_GP,     D_NUM, W_NUM,   AL_NONE};
            4'd2:  return '{UK_DIV, C_APGI,     A_ERR,   B_GP,     D_NUM, W_Q,     AL_NONE};
            4'd3:  return '{UK_DIV, C_APGI,     A_ERR,   B_GP,     D_MIN, W_LO,    AL_NONE};
            4'd4:  return '{UK_DIV, C_APGI,     A_ERR,   B_GP,     D_MAX, W_HI,    AL_NONE};
            4'd5:  return '{UK_ALU, C_APGI,     A_ERR,   B_GP,     D_NUM, W_NONE,  AL_CLAMPI};
            4'd6:  return '{UK_MUL, C_PRIMED,   A_DMEAS, B_RATE,   D_NUM, W_RAW,   AL_NONE};
            4'd7:  return '{UK_MUL, C_PRIMED,   A_FD,    B_ALPHA,  D_NUM, W_FD1,   AL_NONE};
            4'd8:  return '{UK_MUL, C_PRIMED,   A_RAW,   B_NALPHA, D_NUM, W_FD2,   AL_NONE};
            4'd9:  return '{UK_MUL, C_ALWAYS,   A_ERR,   B_PERIOD, D_NUM, W_CAND,  AL_NONE};
            4'd10: return '{UK_MUL, C_ALWAYS,   A_ERR,   B_GP,     D_NUM, W_SUM0,  AL_NONE};
            4'd11: return '{UK_MUL, C_ALWAYS,   A_FD,    B_GD,     D_NUM, W_SUMA,  AL_NONE};
            4'd12: return '{UK_MUL, C_ALWAYS,   A_CAND,  B_GI,     D_NUM, W_UNSAT, AL_NONE};
            4'd13: return '{UK_MUL, C_NOCOMMIT, A_INTEG, B_GI,     D_NUM, W_OUT,   AL_NONE};
            default: return '{UK_ALU, C_ALWAYS, A_ERR,   B_GP,     D_NUM, W_NONE,  AL_FINISH};
        endcase
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [74:0] x);
        if (x > S48_MAX_W) return S48_MAX_W[47:0];
        if (x < S48_MIN_W) return S48_MIN_W[47:0];
        return x[47:0];
    endfunction

    function automatic logic signed [63:0] clamp64(input logic signed [63:0] v,
                                                   input logic signed [63:0] lo,
                                                   input logic signed [63:0] hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

endpackage

### hw/rtl/pidab_if.sv
interface pidab_in_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [31:0] target;
    logic [31:0] actual;
    logic        inputs_valid;
    logic [23:0] new_kp;
    logic [23:0] new_ki;
    logic [23:0] new_kd;

    modport source (output valid, req_type, target, actual, inputs_valid,
                    new_kp, new_ki, new_kd, input ready);
    modport sink   (input valid, req_type, target, actual, inputs_valid,
                    new_kp, new_ki, new_kd, output ready);
endinterface

interface pidab_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] drive;
    logic [2:0]  status;
    logic        gains_applied;

    modport source (output valid, drive, status, gains_applied, input ready);
    modport sink   (input valid, drive, status, gains_applied, output ready);
endinterface

### hw/rtl/pid_antiwindup_bumpless_unit.sv
// A gain request or a fault tick is decoded and then loaded into the output register.
// A valid tick runs its products one at a time on the shared 25x25 multiplier.
// A tick that applies pending gains with a nonzero integral gain adds three 64-step divisions.
// One item at a time; the next is taken once the result sits in the output register.
// Reset: gains, clamps, rate, period and filter weight take their defaults, state clears.
module pid_antiwindup_bumpless_unit
    import pidab_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    pidab_in_if.sink              in_ch,
    pidab_out_if.source           out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    dp_cmd_t   cmd;
    dp_stat_t  stat;
    in_item_t  in_item;
    out_item_t out_item;

    assign in_item = '{in_ch.req_type, in_ch.target, in_ch.actual, in_ch.inputs_valid,
                       in_ch.new_kp, in_ch.new_ki, in_ch.new_kd};

    assign out_ch.drive         = out_item.drive;
    assign out_ch.status        = out_item.status;
    assign out_ch.gains_applied = out_item.gains_applied;

    pidab_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    pidab_dpath u_dpath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_item   (in_item),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

### hw/rtl/pidab_mul.sv
module pidab_mul
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [48:0] a,
    input  logic signed [24:0] b,
    output logic signed [73:0] p,
    output logic               done
);

    logic signed [48:0] a_reg;
    logic signed [24:0] b_reg;
    logic signed [49:0] pp_lo_reg;
    logic signed [49:0] pp_hi_reg;
    logic signed [73:0] p_reg;
    logic [3:0]         v_reg;
    logic signed [24:0] m_a;
    logic signed [49:0] m_p;

    // low chunk first (zero-extended), then the signed high chunk
    assign m_a = v_reg[0] ? $signed({1'b0, a_reg[23:0]}) : $signed(a_reg[48:24]);
    assign m_p = m_a * b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[2:0], start};
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            b_reg <= b;
        end
        if (v_reg[0])
        begin
            pp_lo_reg <= m_p;
        end
        if (v_reg[1])
        begin
            pp_hi_reg <= m_p;
        end
        if (v_reg[2])
        begin
            p_reg <= 74'(pp_lo_reg) + (74'(pp_hi_reg) <<< 24);
        end
    end

    assign p    = p_reg;
    assign done = v_reg[3];

endmodule

### hw/rtl/pidab_div.sv
module pidab_div
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] dividend,
    input  logic [23:0]        divisor,
    output logic signed [63:0] quot,
    output logic               done
);

    logic [63:0] mag_reg;
    logic [23:0] rem_reg;
    logic [23:0] d_reg;
    logic        neg_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [24:0] rem_sh;
    logic        ge;
    logic [24:0] rem_sub;

    assign rem_sh  = {rem_reg, mag_reg[63]};
    assign ge      = rem_sh >= {1'b0, d_reg};
    assign rem_sub = rem_sh - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (&cnt_reg)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // restoring division on magnitudes, one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[63];
            mag_reg <= dividend[63] ? 64'(-dividend) : 64'(dividend);
            rem_reg <= '0;
            d_reg   <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? rem_sub[23:0] : rem_sh[23:0];
            mag_reg <= {mag_reg[62:0], ge};
        end
    end

    assign quot = neg_reg ? -$signed(mag_reg) : $signed(mag_reg);
    assign done = done_reg;

endmodule

### hw/rtl/pidab_dpath.sv
module pidab_dpath
    import pidab_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  dp_cmd_t               cmd,
    output dp_stat_t              stat,
    input  in_item_t              in_item,
    output out_item_t             out_item,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic signed [31:0] omin_reg, omax_reg;
    logic [15:0]        period_reg, rate_reg, alpha_reg;
    logic [23:0]        gp_reg, gi_reg, gd_reg;
    logic [23:0]        pk_reg, pi_reg, pd_reg;
    logic signed [47:0] integ_reg, fd_reg;
    logic signed [31:0] lm_reg, lastout_reg;
    logic               primed_reg, pend_reg, fault_reg, applied_reg, commit_reg;

    in_item_t           in_reg;
    out_item_t          out_reg;
    logic signed [63:0] num_reg, q_reg, lo_reg, hi_reg, sum_reg;
    logic signed [47:0] raw_reg, cand_reg;
    logic signed [74:0] facc_reg;
    logic [31:0]        res_drive;
    logic [2:0]         res_status;
    logic               res_applied;

    logic signed [32:0] err, dmeas;
    logic signed [48:0] mul_a;
    logic signed [24:0] mul_b;
    logic signed [73:0] mul_p;
    logic               mul_done;
    logic signed [63:0] div_n, div_q;
    logic               div_done;
    logic signed [57:0] pq;
    logic signed [63:0] omin64, omax64, unsat, outsum;
    logic signed [63:0] unsat_cl, outsum_cl;
    logic signed [74:0] fd_acc;
    logic               commit;
    logic [16:0]        nalpha;

    assign err    = 33'($signed(in_reg.target)) - 33'($signed(in_reg.actual));
    assign dmeas  = 33'(lm_reg) - 33'($signed(in_reg.actual));
    assign nalpha = 17'd65536 - {1'b0, alpha_reg};
    assign omin64 = 64'(omin_reg);
    assign omax64 = 64'(omax_reg);
    assign pq     = $signed(mul_p[73:16]);
    assign unsat  = sum_reg + 64'(pq);
    assign outsum = sum_reg + 64'(pq);
    assign unsat_cl  = clamp64(unsat, omin64, omax64);
    assign outsum_cl = clamp64(outsum, omin64, omax64);
    assign fd_acc = facc_reg + 75'(mul_p);
    assign commit = (unsat < omax64 && unsat > omin64) ||
                    (unsat >= omax64 && err < 0) ||
                    (unsat <= omin64 && err > 0);

    always_comb
    begin
        case (cmd.asel)
            A_ERR:   mul_a = 49'(err);
            A_DMEAS: mul_a = 49'(dmeas);
            A_RAW:   mul_a = 49'(raw_reg);
            A_FD:    mul_a = 49'(fd_reg);
            A_CAND:  mul_a = 49'(cand_reg);
            A_INTEG: mul_a = 49'(integ_reg);
            default: mul_a = '0;
        endcase
        case (cmd.bsel)
            B_GP:     mul_b = $signed({1'b0, gp_reg});
            B_GI:     mul_b = $signed({1'b0, gi_reg});
            B_GD:     mul_b = $signed({1'b0, gd_reg});
            B_RATE:   mul_b = $signed({9'd0, rate_reg});
            B_PERIOD: mul_b = $signed({9'd0, period_reg});
            B_ALPHA:  mul_b = $signed({9'd0, alpha_reg});
            B_NALPHA: mul_b = $signed({8'd0, nalpha});
            default:  mul_b = '0;
        endcase
        case (cmd.dsel)
            D_NUM:   div_n = num_reg <<< 16;
            D_MIN:   div_n = omin64 <<< 16;
            D_MAX:   div_n = omax64 <<< 16;
            default: div_n = '0;
        endcase
    end

    pidab_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .p     (mul_p),
        .done  (mul_done)
    );

    pidab_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_n),
        .divisor  (gi_reg),
        .quot     (div_q),
        .done     (div_done)
    );

    // regulator state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            omin_reg    <= $signed(RST_OMIN);
            omax_reg    <= $signed(RST_OMAX);
            period_reg  <= RST_PERIOD;
            rate_reg    <= RST_RATE;
            alpha_reg   <= RST_ALPHA;
            gp_reg      <= RST_KP;
            gi_reg      <= RST_KI;
            gd_reg      <= RST_KD;
            pk_reg      <= '0;
            pi_reg      <= '0;
            pd_reg      <= '0;
            integ_reg   <= '0;
            fd_reg      <= '0;
            lm_reg      <= '0;
            lastout_reg <= '0;
            primed_reg  <= 1'b0;
            pend_reg    <= 1'b0;
            fault_reg   <= 1'b0;
            applied_reg <= 1'b0;
            commit_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_OMIN:   omin_reg   <= $signed(cfg_data);
                    CFG_OMAX:   omax_reg   <= $signed(cfg_data);
                    CFG_PERIOD: period_reg <= cfg_data[15:0];
                    CFG_RATE:   rate_reg   <= cfg_data[15:0];
                    CFG_ALPHA:  alpha_reg  <= cfg_data[15:0];
                    CFG_KP:     gp_reg     <= cfg_data[23:0];
                    CFG_KI:     gi_reg     <= cfg_data[23:0];
                    CFG_KD:     gd_reg     <= cfg_data[23:0];
                    default:    ;
                endcase
            end
            case (cmd.tick)
                TK_REQ:
                begin
                    if (!pend_reg)
                    begin
                        pend_reg <= 1'b1;
                        pk_reg   <= in_reg.new_kp;
                        pi_reg   <= in_reg.new_ki;
                        pd_reg   <= in_reg.new_kd;
                    end
                end
                TK_FAULT: fault_reg <= 1'b1;
                TK_VALID:
                begin
                    fault_reg   <= 1'b0;
                    applied_reg <= 1'b0;
                end
                default: ;
            endcase
            case (cmd.alu)
                AL_APPLY:
                begin
                    gp_reg      <= pk_reg;
                    gi_reg      <= pi_reg;
                    gd_reg      <= pd_reg;
                    fd_reg      <= '0;
                    integ_reg   <= '0;
                    primed_reg  <= 1'b0;
                    pend_reg    <= 1'b0;
                    applied_reg <= 1'b1;
                end
                AL_CLAMPI: integ_reg <= sat48(75'(clamp64(q_reg, lo_reg, hi_reg)));
                AL_FINISH:
                begin
                    lastout_reg <= $signed(res_drive);
                    lm_reg      <= $signed(in_reg.actual);
                    primed_reg  <= 1'b1;
                end
                default: ;
            endcase
            case (cmd.wb)
                W_FD2: fd_reg <= sat48(75'($signed(fd_acc[74:16])));
                W_UNSAT:
                begin
                    commit_reg <= commit;
                    if (commit)
                    begin
                        integ_reg <= cand_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    // per-item working values and the output register
    always_ff @(posedge clk)
    begin
        if (cmd.take_in)
        begin
            in_reg <= in_item;
        end
        case (cmd.tick)
            TK_REQ:
            begin
                res_drive   <= '0;
                res_status  <= pend_reg ? ST_REQ_BUSY : ST_REQ_OK;
                res_applied <= 1'b0;
            end
            TK_FAULT:
            begin
                res_drive   <= '0;
                res_status  <= fault_reg ? ST_FAULT_AGAIN : ST_FAULT_FIRST;
                res_applied <= 1'b0;
            end
            default: ;
        endcase
        if (cmd.alu == AL_FINISH)
        begin
            res_status  <= ST_NORMAL;
            res_applied <= applied_reg;
        end
        case (cmd.wb)
            W_NUM:   num_reg  <= 64'(lastout_reg) - 64'(pq);
            W_RAW:   raw_reg  <= sat48(75'(mul_p));
            W_FD1:   facc_reg <= 75'(mul_p);
            W_CAND:  cand_reg <= sat48(75'(integ_reg) + 75'(pq));
            W_SUM0:  sum_reg  <= 64'(pq);
            W_SUMA:  sum_reg  <= sum_reg + 64'(pq);
            W_UNSAT: res_drive <= unsat_cl[31:0];
            W_OUT:   res_drive <= outsum_cl[31:0];
            W_Q:     q_reg    <= div_q;
            W_LO:    lo_reg   <= div_q;
            W_HI:    hi_reg   <= div_q;
            default: ;
        endcase
        if (cmd.load_out)
        begin
            out_reg <= '{res_drive, res_status, res_applied};
        end
    end

    assign out_item = out_reg;

    assign stat.req_type     = in_reg.req_type;
    assign stat.inputs_valid = in_reg.inputs_valid;
    assign stat.pend_valid   = pend_reg;
    assign stat.primed       = primed_reg;
    assign stat.applied      = applied_reg;
    assign stat.gi_nz        = |gi_reg;
    assign stat.commit       = commit_reg;
    assign stat.mul_done     = mul_done;
    assign stat.div_done     = div_done;

endmodule

### hw/rtl/pidab_ctrl.sv
module pidab_ctrl
    import pidab_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_DECODE   = 6'b000010,
        S_RUN      = 6'b000100,
        S_WAIT_MUL = 6'b001000,
        S_WAIT_DIV = 6'b010000,
        S_OUT      = 6'b100000
    } state_t;

    state_t          state_reg, state_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    logic            out_valid_reg, out_valid_next;
    uop_t            u;
    logic            cond_ok;
    logic            adv;

    assign u        = get_uop(pc_reg);
    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        case (u.cond)
            C_ALWAYS:   cond_ok = 1'b1;
            C_PEND:     cond_ok = stat.pend_valid;
            C_APGI:     cond_ok = stat.applied & stat.gi_nz;
            C_PRIMED:   cond_ok = stat.primed;
            C_NOCOMMIT: cond_ok = ~stat.commit;
            default:    cond_ok = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        adv            = 1'b0;
        cmd            = '0;
        cmd.take_in    = in_valid & in_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.req_type)
                begin
                    cmd.tick   = TK_REQ;
                    state_next = S_OUT;
                end
                else if (!stat.inputs_valid)
                begin
                    cmd.tick   = TK_FAULT;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.tick   = TK_VALID;
                    pc_next    = '0;
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (!cond_ok)
                begin
                    adv = 1'b1;
                end
                else
                begin
                    case (u.kind)
                        UK_MUL:
                        begin
                            cmd.mul_start = 1'b1;
                            cmd.asel      = u.asel;
                            cmd.bsel      = u.bsel;
                            state_next    = S_WAIT_MUL;
                        end
                        UK_DIV:
                        begin
                            cmd.div_start = 1'b1;
                            cmd.dsel      = u.dsel;
                            state_next    = S_WAIT_DIV;
                        end
                        default:
                        begin
                            cmd.alu = u.alu;
                            adv     = 1'b1;
                        end
                    endcase
                end
            end
            S_WAIT_MUL:
            begin
                if (stat.mul_done)
                begin
                    cmd.wb = u.wb;
                    adv    = 1'b1;
                end
            end
            S_WAIT_DIV:
            begin
                cmd.dsel = u.dsel;
                if (stat.div_done)
                begin
                    cmd.wb = u.wb;
                    adv    = 1'b1;
                end
            end
            S_OUT:
            begin
                // hold until the previous beat has left the output register
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
        if (adv)
        begin
            if (pc_reg == PC_LAST)
            begin
                state_next = S_OUT;
            end
            else
            begin
                pc_next    = pc_reg + 1'b1;
                state_next = S_RUN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### hw/rtl/pidab_chk.sv
`include "pid_antiwindup_bumpless_unit_assert.svh"

module pidab_chk
    import pidab_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] drive,
    input logic [2:0]  status,
    input logic        gains_applied
);

    `PIDAB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(drive) && $stable(status) && $stable(gains_applied))
    `PIDAB_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready)
    `PIDAB_ASSERT_NOW(a_zero_drive, out_valid && status != ST_NORMAL, drive == 32'd0)
    `PIDAB_ASSERT_NOW(a_applied_normal, out_valid && gains_applied, status == ST_NORMAL)

endmodule

bind pid_antiwindup_bumpless_unit pidab_chk u_chk
(
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .drive         (out_ch.drive),
    .status        (out_ch.status),
    .gains_applied (out_ch.gains_applied)
);
